/* rtl/dlf_pkg.sv */
// shared types, constants and tables for the dense layer forward block
package dlf_pkg;

  typedef enum logic [1:0] {
    OP_WEIGHT  = 2'd0,
    OP_BIAS    = 2'd1,
    OP_FEATURE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_LINEAR  = 2'd0,
    ACT_SIGMOID = 2'd1,
    ACT_RELU    = 2'd2,
    ACT_LEAKY   = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    REG_ACT_MODE  = 3'd0,
    REG_SQ_EN     = 3'd1,
    REG_SQ_INV    = 3'd2,
    REG_SQ_SCALE  = 3'd3,
    REG_IN_COUNT  = 3'd4,
    REG_OUT_COUNT = 3'd5
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC_RD,
    ST_MAC_EX,
    ST_EMIT_RD,
    ST_EMIT_Z,
    ST_EMIT_ACT,
    ST_EMIT_SQ1,
    ST_EMIT_SQ2,
    ST_EMIT_SQ3,
    ST_EMIT_OUT
  } state_e;

  localparam int unsigned ACC_BITS  = 40;
  localparam int unsigned FRAC_BITS = 12;
  localparam logic [15:0] INV_DEFAULT   = 16'd6554;
  localparam logic [15:0] SCALE_DEFAULT = 16'd2560;
  localparam logic [9:0]  LEAKY_SLOPE   = 10'd655;

  // controller commands to the datapath
  typedef struct packed {
    logic mac_rd;     // read weight for current column
    logic mac_ex;     // multiply-accumulate current column
    logic emit_rd;    // read accumulator and bias
    logic emit_z;     // form z
    logic emit_act;   // plain activation / squash first step
    logic sq1;
    logic sq2;
    logic sq3;
    logic emit_out;   // present result
    logic col_clr;
    logic col_inc;
    logic acc_clr;
  } dp_cmd_t;

  function automatic logic [11:0] sig_tab(input logic [4:0] i);
    logic [11:0] r;
    case (i)
      5'd0: r = 12'd2048;  5'd1: r = 12'd2550;  5'd2: r = 12'd2994;
      5'd3: r = 12'd3349;  5'd4: r = 12'd3608;  5'd5: r = 12'd3785;
      5'd6: r = 12'd3902;  5'd7: r = 12'd3976;  5'd8: r = 12'd4022;
      5'd9: r = 12'd4051;  5'd10: r = 12'd4069; 5'd11: r = 12'd4079;
      5'd12: r = 12'd4086; 5'd13: r = 12'd4090; 5'd14: r = 12'd4092;
      5'd15: r = 12'd4094; default: r = 12'd4095;
    endcase
    return r;
  endfunction

  // sigmoid of a Q4.12 value, result 0..4096
  function automatic logic [12:0] sigmoid_q12(input logic signed [15:0] x);
    logic [15:0] a;
    logic [3:0]  idx;
    logic [10:0] frac;
    logic [11:0] y0;
    logic [11:0] y1;
    logic [22:0] prod;
    logic [12:0] y;
    a    = x[15] ? 16'(-{x[15], x}) : 16'(x);
    if (a > 16'd32767) a = 16'd32767;
    idx  = a[14:11];
    frac = a[10:0];
    y0   = sig_tab({1'b0, idx});
    y1   = sig_tab({1'b0, idx} + 5'd1);
    prod = 23'(y1 - y0) * 23'(frac) + 23'd1024;
    y    = 13'(y0) + 13'(prod[22:11]);
    return x[15] ? 13'd4096 - y : y;
  endfunction

endpackage

/* rtl/dlf_ram.sv */
// generic ram, one write port and one read port, with registered read
module dlf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/dlf_ctrl.sv */
// controller state machine for the dense layer forward block
module dlf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  dlf_pkg::op_e    op_i,
  input  logic            row_ok_i,
  input  logic            row_last_i,
  input  logic            col_last_i,
  input  logic            squash_i,
  output logic            busy_o,
  output dlf_pkg::dp_cmd_t cmd_o
);
  import dlf_pkg::*;

  state_e state_q, state_d;
  logic   emit_q, emit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
    end
  end

  always_comb begin
    state_d = state_q;
    emit_d  = emit_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i && op_i == OP_FEATURE && row_ok_i) begin
          state_d = ST_MAC_RD;
          emit_d  = row_last_i;
        end
      end
      ST_MAC_RD: state_d = ST_MAC_EX;
      ST_MAC_EX: begin
        if (!col_last_i) state_d = ST_MAC_RD;
        else if (emit_q) state_d = ST_EMIT_RD;
        else state_d = ST_IDLE;
      end
      ST_EMIT_RD:  state_d = ST_EMIT_Z;
      ST_EMIT_Z:   state_d = ST_EMIT_ACT;
      ST_EMIT_ACT: state_d = squash_i ? ST_EMIT_SQ1 : ST_EMIT_OUT;
      ST_EMIT_SQ1: state_d = ST_EMIT_SQ2;
      ST_EMIT_SQ2: state_d = ST_EMIT_SQ3;
      ST_EMIT_SQ3: state_d = ST_EMIT_OUT;
      ST_EMIT_OUT: state_d = col_last_i ? ST_IDLE : ST_EMIT_RD;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE:     cmd_o.col_clr = 1'b1;
      ST_MAC_RD:   cmd_o.mac_rd = 1'b1;
      ST_MAC_EX: begin
        cmd_o.mac_ex = 1'b1;
        if (col_last_i) cmd_o.col_clr = 1'b1;
        else cmd_o.col_inc = 1'b1;
      end
      ST_EMIT_RD:  cmd_o.emit_rd = 1'b1;
      ST_EMIT_Z:   cmd_o.emit_z = 1'b1;
      ST_EMIT_ACT: cmd_o.emit_act = 1'b1;
      ST_EMIT_SQ1: cmd_o.sq1 = 1'b1;
      ST_EMIT_SQ2: cmd_o.sq2 = 1'b1;
      ST_EMIT_SQ3: cmd_o.sq3 = 1'b1;
      ST_EMIT_OUT: begin
        cmd_o.emit_out = 1'b1;
        if (col_last_i) begin
          cmd_o.col_clr = 1'b1;
          cmd_o.acc_clr = 1'b1;
        end else cmd_o.col_inc = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

/* rtl/dlf_dp.sv */
// datapath: weight and bias stores, shared mac, accumulators and activation
module dlf_dp #(
  parameter int unsigned MaxInputs  = 64,
  parameter int unsigned MaxOutputs = 16,
  parameter int unsigned DataBits   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  dlf_pkg::op_e           op_i,
  input  logic [5:0]             row_index_i,
  input  logic [3:0]             col_index_i,
  input  logic signed [15:0]     value_i,
  input  dlf_pkg::dp_cmd_t       cmd_i,
  input  dlf_pkg::act_e          act_mode_i,
  input  logic                   squash_i,
  input  logic [15:0]            inv_i,
  input  logic [15:0]            scale_i,
  input  logic [6:0]             in_count_i,
  input  logic [4:0]             out_count_i,
  output logic                   row_ok_o,
  output logic                   row_last_o,
  output logic                   col_last_o,
  output logic                   out_valid_o,
  output logic [3:0]             out_index_o,
  output logic signed [15:0]     out_value_o,
  output logic                   last_o
);
  import dlf_pkg::*;

  localparam int unsigned RowBits = (MaxInputs > 1) ? $clog2(MaxInputs) : 1;
  localparam int unsigned ColBits = (MaxOutputs > 1) ? $clog2(MaxOutputs) : 1;
  localparam int unsigned WDepth  = MaxInputs * MaxOutputs;
  localparam int unsigned WaBits  = $clog2(WDepth);
  localparam logic signed [ACC_BITS-1:0] AccMax = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] AccMin = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic signed [47:0] DMax = 48'((64'sd1 <<< (DataBits - 1)) - 1);
  localparam logic signed [47:0] DMin = -DMax - 48'sd1;

  // effective counts: zero taken as one, clamped to the stored dimensions
  logic [10:0] ni, no;
  always_comb begin
    ni = 11'(in_count_i);
    if (ni == '0) ni = 11'd1;
    if (ni > 11'(MaxInputs)) ni = 11'(MaxInputs);
    no = 11'(out_count_i);
    if (no == '0) no = 11'd1;
    if (no > 11'(MaxOutputs)) no = 11'(MaxOutputs);
  end

  logic accept;
  assign accept = start_i && !busy_i;

  // captured feature
  logic [RowBits-1:0]  row_q;
  logic signed [15:0]  feat_q;
  logic [ColBits-1:0]  col_q, col_d;

  assign row_ok_o   = 11'(row_index_i) < ni;
  assign row_last_o = 11'(row_index_i) == ni - 11'd1;
  assign col_last_o = 11'(col_q) == no - 11'd1;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q  <= RowBits'(row_index_i);
      feat_q <= value_i;
    end
  end

  always_comb begin
    col_d = col_q;
    if (cmd_i.col_clr) col_d = '0;
    else if (cmd_i.col_inc) col_d = col_q + ColBits'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) col_q <= '0;
    else col_q <= col_d;
  end

  // weight memory
  logic              w_we;
  logic [WaBits-1:0] w_waddr, w_raddr;
  logic [15:0]       w_rdata;
  assign w_we    = accept && op_i == OP_WEIGHT && 32'(row_index_i) < MaxInputs
                   && 32'(col_index_i) < MaxOutputs;
  assign w_waddr = WaBits'(32'(row_index_i) * MaxOutputs + 32'(col_index_i));
  assign w_raddr = WaBits'(32'(row_q) * MaxOutputs + 32'(col_q));

  dlf_ram #(.Width(16), .Depth(WDepth)) u_wram (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(value_i),
    .raddr_i(w_raddr), .rdata_o(w_rdata)
  );

  // bias memory
  logic               b_we;
  logic [15:0]        b_rdata;
  assign b_we = accept && op_i == OP_BIAS && 32'(col_index_i) < MaxOutputs;

  dlf_ram #(.Width(16), .Depth(MaxOutputs)) u_bram (
    .clk_i, .we_i(b_we), .waddr_i(ColBits'(col_index_i)), .wdata_i(value_i),
    .raddr_i(col_q), .rdata_o(b_rdata)
  );

  // accumulators, cleared after emit
  logic signed [ACC_BITS-1:0] acc_q [MaxOutputs];
  logic signed [31:0]         prod;
  logic signed [ACC_BITS:0]   acc_sum;
  assign prod    = feat_q * $signed(w_rdata);
  assign acc_sum = {acc_q[col_q][ACC_BITS-1], acc_q[col_q]} + (ACC_BITS+1)'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxOutputs; i++) acc_q[i] <= '0;
    end else if (cmd_i.acc_clr) begin
      for (int i = 0; i < MaxOutputs; i++) acc_q[i] <= '0;
    end else if (cmd_i.mac_ex) begin
      if (acc_sum[ACC_BITS] != acc_sum[ACC_BITS-1])
        acc_q[col_q] <= acc_sum[ACC_BITS] ? AccMin : AccMax;
      else acc_q[col_q] <= acc_sum[ACC_BITS-1:0];
    end
  end

  // emit pipeline registers
  logic signed [ACC_BITS-1:0] eacc_q;
  logic signed [29:0]         z_q;      // rounded z, Q.12
  logic signed [47:0]         r_q;      // result before saturation
  logic signed [47:0]         u_q;
  logic signed [15:0]         t_q;
  logic [15:0]                inv_eff, scale_eff;
  assign inv_eff   = (inv_i == '0) ? INV_DEFAULT : inv_i;
  assign scale_eff = (scale_i == '0) ? SCALE_DEFAULT : scale_i;

  function automatic logic signed [15:0] sat16(input logic signed [47:0] x);
    if (x > 48'sd32767) return 16'sh7fff;
    if (x < -48'sd32768) return 16'sh8000;
    return x[15:0];
  endfunction

  logic signed [ACC_BITS+1:0] zsum;
  assign zsum = 42'(eacc_q) + (42'($signed(b_rdata)) <<< FRAC_BITS)
                + 42'sd2048;

  logic signed [47:0] zl;
  logic signed [15:0] z16;
  logic signed [47:0] leaky_p;
  logic signed [47:0] inv_p;
  logic signed [47:0] sc_p;
  logic signed [16:0] two_u;
  logic signed [15:0] u16;
  assign zl      = 48'(z_q);
  assign z16     = sat16(zl);
  assign leaky_p = zl * 48'(LEAKY_SLOPE) + 48'sd32768;
  assign inv_p   = zl * 48'(inv_eff) + 48'sd32768;
  assign u16     = sat16(u_q);
  assign two_u   = {u16, 1'b0};
  assign sc_p    = 48'(t_q) * 48'(scale_eff) + 48'sd128;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_rd) eacc_q <= acc_q[col_q];
    if (cmd_i.emit_z) z_q <= 30'(zsum >>> FRAC_BITS);
    if (cmd_i.emit_act) begin
      if (squash_i) u_q <= inv_p >>> 16;
      else begin
        unique case (act_mode_i)
          ACT_SIGMOID: r_q <= 48'(sigmoid_q12(z16));
          ACT_RELU:    r_q <= z_q[29] ? '0 : zl;
          ACT_LEAKY:   r_q <= z_q[29] ? (leaky_p >>> 16) : zl;
          default:     r_q <= zl;
        endcase
      end
    end
    if (cmd_i.sq1) t_q <= 16'(sigmoid_q12(sat16(48'(two_u)))) * 16'sd2 - 16'sd4096;
    if (cmd_i.sq2) u_q <= sc_p;
    if (cmd_i.sq3) r_q <= u_q >>> 8;
  end

  // result register, one cycle strobe
  logic r_valid_q;
  logic [3:0] oi_q;
  logic signed [15:0] ov_q;
  logic ol_q;
  logic signed [47:0] rs;
  assign rs = (r_q > DMax) ? DMax : ((r_q < DMin) ? DMin : r_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) r_valid_q <= 1'b0;
    else r_valid_q <= cmd_i.emit_out;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_out) begin
      oi_q <= 4'(col_q);
      ov_q <= rs[15:0];
      ol_q <= col_last_o;
    end
  end

  assign out_valid_o = r_valid_q;
  assign out_index_o = oi_q;
  assign out_value_o = ov_q;
  assign last_o      = ol_q;
endmodule

/* rtl/dense_layer_forward_top.sv */
// dense layer forward top level: config registers, controller and datapath
// weight, bias and ignored items leave busy low
// a feature in use holds busy while it sweeps the output neurons in use (weight read, mac)
// final feature then emits each result in turn: accumulator and bias read, z, activation,
// squash states sq1..sq3 when enabled, output register; results follow with no stall
// rst_ni async active low clears registers and accumulators, stores undefined
module dense_layer_forward_top #(
  parameter int unsigned MAX_INPUTS  = 64,
  parameter int unsigned MAX_OUTPUTS = 16,
  parameter int unsigned DATA_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op_i,
  input  logic [5:0]         row_index_i,
  input  logic [3:0]         col_index_i,
  input  logic signed [15:0] value_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               out_valid_o,
  output logic [3:0]         out_index_o,
  output logic signed [15:0] out_value_o,
  output logic               last_o
);
  import dlf_pkg::*;

  // configuration registers
  logic [1:0]  act_q;
  logic        sq_en_q;
  logic [15:0] inv_q, scale_q;
  logic [6:0]  in_cnt_q;
  logic [4:0]  out_cnt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 2'd0;
      sq_en_q   <= 1'b0;
      inv_q     <= INV_DEFAULT;
      scale_q   <= SCALE_DEFAULT;
      in_cnt_q  <= 7'd64;
      out_cnt_q <= 5'd16;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_ACT_MODE:  act_q     <= cfg_data_i[1:0];
        REG_SQ_EN:     sq_en_q   <= cfg_data_i[0];
        REG_SQ_INV:    inv_q     <= cfg_data_i;
        REG_SQ_SCALE:  scale_q   <= cfg_data_i;
        REG_IN_COUNT:  in_cnt_q  <= cfg_data_i[6:0];
        REG_OUT_COUNT: out_cnt_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t cmd;
  logic    row_ok, row_last, col_last;

  // sequencer for mac sweep and emit
  dlf_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .op_i(op_e'(op_i)),
    .row_ok_i(row_ok), .row_last_i(row_last), .col_last_i(col_last),
    .squash_i(sq_en_q), .busy_o(busy), .cmd_o(cmd)
  );

  // stores, mac and activation units
  dlf_dp #(
    .MaxInputs(MAX_INPUTS), .MaxOutputs(MAX_OUTPUTS), .DataBits(DATA_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .op_i(op_e'(op_i)),
    .row_index_i, .col_index_i, .value_i, .cmd_i(cmd),
    .act_mode_i(act_e'(act_q)), .squash_i(sq_en_q), .inv_i(inv_q),
    .scale_i(scale_q), .in_count_i(in_cnt_q), .out_count_i(out_cnt_q),
    .row_ok_o(row_ok), .row_last_o(row_last), .col_last_o(col_last),
    .out_valid_o, .out_index_o, .out_value_o, .last_o
  );
endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the dense layer forward block
`timescale 1ns / 100ps

module tb_top;
  import dlf_pkg::*;

  localparam int NI = 64;
  localparam int NO = 16;

  typedef struct {
    op_e             op;
    logic [5:0]      row;
    logic [3:0]      col;
    logic signed [15:0] val;
  } layer_item_t;

  typedef struct {
    logic [3:0]  idx;
    logic [15:0] val;
    logic        last;
  } neuron_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] op_i = '0;
  logic [5:0] row_index_i = '0;
  logic [3:0] col_index_i = '0;
  logic signed [15:0] value_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic out_valid_o;
  logic [3:0] out_index_o;
  logic signed [15:0] out_value_o;
  logic last_o;

  dense_layer_forward_top dut (.*);

  // clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: registers, stores and accumulators
  logic [1:0]  act_mode = ACT_LINEAR;
  logic        sq_en = 1'b0;
  logic [15:0] sq_inv = 16'd6554;
  logic [15:0] sq_scale = 16'd2560;
  logic [6:0]  n_in = 7'd64;
  logic [4:0]  n_out = 5'd16;
  logic signed [15:0] weights [NI*NO];
  logic signed [15:0] biases [NO];
  longint acc [NO];

  layer_item_t pending_items[$];
  neuron_out_t expected_outs[$];
  int          sender_idle_pct = 0;
  int          n_errors = 0;
  bit          item_in_flight = 1'b0;

  localparam longint ACC_MAX = 64'sd549755813887;
  localparam longint ACC_MIN = -64'sd549755813888;

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // floor((x + 2^(s-1)) / 2^s)
  function automatic longint rnd_shift(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sig_lookup(longint z);
    longint x, a, i, f, y0, y1, y;
    x = clip(z, -32768, 32767);
    a = x < 0 ? -x : x;
    if (a > 32767) a = 32767;
    i = a >>> 11;
    f = a & 2047;
    y0 = sig_tab(5'(i));
    y1 = sig_tab(5'(i + 1));
    y = y0 + (((y1 - y0) * f + 1024) >>> 11);
    return x < 0 ? 4096 - y : y;
  endfunction

  function automatic longint neuron_activation(longint z);
    longint inv, so, u, t;
    if (sq_en) begin
      inv = sq_inv != 0 ? sq_inv : 6554;
      so = sq_scale != 0 ? sq_scale : 2560;
      u = clip(rnd_shift(z * inv, 16), -32768, 32767);
      t = 2 * sig_lookup(clip(2 * u, -32768, 32767)) - 4096;
      return clip(rnd_shift(t * so, 8), -32768, 32767);
    end
    case (act_e'(act_mode))
      ACT_SIGMOID: return clip(sig_lookup(z), -32768, 32767);
      ACT_RELU:    return z < 0 ? 0 : clip(z, -32768, 32767);
      ACT_LEAKY:   return clip(z < 0 ? rnd_shift(z * 655, 16) : z, -32768, 32767);
      default:     return clip(z, -32768, 32767);
    endcase
  endfunction

  // apply one accepted item to the layer state and queue the outputs it causes
  task automatic layer_step(layer_item_t it);
    int ni, no;
    longint z;
    ni = n_in < 1 ? 1 : (n_in > NI ? NI : n_in);
    no = n_out < 1 ? 1 : (n_out > NO ? NO : n_out);
    case (it.op)
      OP_WEIGHT: weights[it.row * NO + it.col] = it.val;
      OP_BIAS:   biases[it.col] = it.val;
      OP_FEATURE: if (it.row < ni) begin
        for (int c = 0; c < no; c++)
          acc[c] = clip(acc[c] + longint'(it.val) * longint'(weights[it.row * NO + c]),
                        ACC_MIN, ACC_MAX);
        if (it.row == ni - 1) begin
          for (int c = 0; c < no; c++) begin
            z = rnd_shift(acc[c] + longint'(biases[c]) * 4096, 12);
            expected_outs.push_back('{4'(c), 16'(neuron_activation(z)), c == no - 1});
          end
          for (int c = 0; c < NO; c++) acc[c] = 0;
        end
      end
      default: ;
    endcase
  endtask

  // driver: one item per start/busy handshake, random idle cycles
  always @(posedge clk_i) begin
    layer_item_t it;
    if (rst_ni) begin
      if (start && !busy) begin
        layer_step('{op_e'(op_i), row_index_i, col_index_i, value_i});
      end
      if ((start && !busy) || !start) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          it = pending_items.pop_front();
          start <= 1'b1;
          op_i <= it.op;
          row_index_i <= it.row;
          col_index_i <= it.col;
          value_i <= it.val;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @* item_in_flight = start;

  // monitor: compare every strobed result with the oldest expectation
  always @(posedge clk_i) begin
    neuron_out_t e;
    if (rst_ni && out_valid_o) begin
      if (expected_outs.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected result idx=%0d val=%0d last=%0d",
                   out_index_o, out_value_o, last_o);
      end else begin
        e = expected_outs.pop_front();
        if (e.idx !== out_index_o || e.val !== out_value_o || e.last !== last_o) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch exp idx=%0d val=%0d last=%0d got idx=%0d val=%0d last=%0d",
                     e.idx, $signed(e.val), e.last, out_index_o, out_value_o, last_o);
        end
      end
    end
  end

  // register write through the config channel, block idle
  task automatic write_reg(reg_e r, logic [15:0] d);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (r)
      REG_ACT_MODE:  act_mode = d[1:0];
      REG_SQ_EN:     sq_en = d[0];
      REG_SQ_INV:    sq_inv = d;
      REG_SQ_SCALE:  sq_scale = d;
      REG_IN_COUNT:  n_in = d[6:0];
      REG_OUT_COUNT: n_out = d[4:0];
      default: ;
    endcase
  endtask

  // wait until every queued item is taken and every result seen
  task automatic drain();
    while (pending_items.size() > 0 || item_in_flight || expected_outs.size() > 0 || busy)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_val();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  // if reload is set, load all weights in use and biases, then feed one sample
  task automatic queue_sample(int ni, int no, bit reload);
    if (reload) begin
      for (int r = 0; r < ni; r++)
        for (int c = 0; c < no; c++)
          pending_items.push_back('{OP_WEIGHT, 6'(r), 4'(c), rand_val()});
      for (int c = 0; c < no; c++)
        pending_items.push_back('{OP_BIAS, 6'd0, 4'(c), rand_val()});
    end
    for (int r = 0; r < ni; r++) begin
      // occasional ignored items mixed into the sample
      if ($urandom_range(9) == 0)
        pending_items.push_back('{OP_NONE, 6'($urandom), 4'($urandom), 16'($urandom)});
      if ($urandom_range(9) == 0 && ni < NI)
        pending_items.push_back('{OP_FEATURE, 6'($urandom_range(63, ni)), 4'($urandom),
                                  rand_val()});
      pending_items.push_back('{OP_FEATURE, 6'(r), 4'($urandom), rand_val()});
    end
  endtask

  initial begin
    int ni, no;
    for (int i = 0; i < NI*NO; i++) weights[i] = '0;
    for (int i = 0; i < NO; i++) begin
      biases[i] = '0;
      acc[i] = 0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: small layer, extremes, all activations and squash edge scales
    write_reg(REG_IN_COUNT, 16'd2);
    write_reg(REG_OUT_COUNT, 16'd2);
    pending_items.push_back('{OP_WEIGHT, 6'd0, 4'd0, 16'sh7fff});
    pending_items.push_back('{OP_WEIGHT, 6'd0, 4'd1, 16'sh8000});
    pending_items.push_back('{OP_WEIGHT, 6'd1, 4'd0, 16'sh8000});
    pending_items.push_back('{OP_WEIGHT, 6'd1, 4'd1, 16'sh1000});
    pending_items.push_back('{OP_BIAS, 6'd63, 4'd0, 16'sh7fff});
    pending_items.push_back('{OP_BIAS, 6'd0, 4'd1, 16'sh8000});
    pending_items.push_back('{OP_NONE, 6'd63, 4'd15, 16'sh7fff});
    pending_items.push_back('{OP_FEATURE, 6'd63, 4'd15, 16'sh7fff});
    pending_items.push_back('{OP_FEATURE, 6'd0, 4'd0, 16'sh7fff});
    pending_items.push_back('{OP_FEATURE, 6'd1, 4'd0, 16'sh8000});
    drain();
    for (int m = ACT_SIGMOID; m <= ACT_LEAKY; m++) begin
      write_reg(REG_ACT_MODE, 16'(m));
      queue_sample(2, 2, 1'b0);
      drain();
    end
    write_reg(REG_SQ_EN, 16'd1);
    write_reg(REG_SQ_INV, 16'd0);
    write_reg(REG_SQ_SCALE, 16'd0);
    queue_sample(2, 2, 1'b0);
    drain();
    write_reg(REG_SQ_INV, 16'hffff);
    write_reg(REG_SQ_SCALE, 16'hffff);
    queue_sample(2, 2, 1'b0);
    drain();
    write_reg(REG_SQ_INV, 16'd1);
    write_reg(REG_SQ_SCALE, 16'd1);
    queue_sample(2, 2, 1'b0);
    drain();
    // clamped counts: zero acts as one
    write_reg(REG_IN_COUNT, 16'd0);
    write_reg(REG_OUT_COUNT, 16'd0);
    write_reg(REG_SQ_EN, 16'd0);
    queue_sample(1, 1, 1'b1);
    drain();

    // random phases, sender idling 25 %, 75 %, then none; last one uses every neuron
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = ph == 0 ? 25 : (ph == 1 ? 75 : 0);
      ni = (ph == 2) ? 1 : $urandom_range(1, 4);
      no = (ph == 2) ? 16 : $urandom_range(1, 6);
      write_reg(REG_ACT_MODE, 16'($urandom_range(3)));
      write_reg(REG_SQ_EN, 16'($urandom_range(1)));
      write_reg(REG_SQ_INV, 16'($urandom_range(65535)));
      write_reg(REG_SQ_SCALE, 16'($urandom_range(65535)));
      write_reg(REG_IN_COUNT, 16'(ni));
      write_reg(REG_OUT_COUNT, 16'(no));
      queue_sample(ni, no, 1'b1);
      queue_sample(ni, no, 1'b0);
      drain();
    end

    if (n_errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

/* sim.f */
rtl/dlf_pkg.sv
rtl/dlf_ram.sv
rtl/dlf_ctrl.sv
rtl/dlf_dp.sv
rtl/dense_layer_forward_top.sv
tb/sv/tb_top.sv
